>>> src/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared constants, codes and types of the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int SLOTS        = 2048;
    localparam int TABLES       = 2;
    localparam int SLOT_BITS    = $clog2(SLOTS);          // slot index width
    localparam int HEAD_BITS    = SLOT_BITS + 1;          // holds SLOTS as empty mark
    localparam int TBL_BITS     = $clog2(TABLES);
    localparam int ADDR_BITS    = TBL_BITS + SLOT_BITS;   // entry address
    localparam int VERSION_BITS = 24;
    localparam int PAYLOAD_BITS = 32;

    localparam logic [HEAD_BITS-1:0]    EMPTY_MARK  = HEAD_BITS'(SLOTS);
    localparam logic [VERSION_BITS-1:0] VERSION_MAX = '1;

    // opcodes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // one memory word: all per-slot state
    typedef struct packed {
        logic                    live;
        logic [HEAD_BITS-1:0]    free_link;
        logic [VERSION_BITS-1:0] version;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // transaction in flight plus the table's list state
    typedef struct packed {
        logic [1:0]              op;
        logic [TBL_BITS-1:0]     tbl;
        logic [SLOT_BITS-1:0]    slot;
        logic [VERSION_BITS-1:0] ver;
        logic [PAYLOAD_BITS-1:0] pay;
        logic [HEAD_BITS-1:0]    head;
        logic [HEAD_BITS-1:0]    used;
    } t_req;

    // result and update requests from the execute stage
    typedef struct packed {
        logic [1:0]              status;
        logic [SLOT_BITS-1:0]    slot;
        logic [VERSION_BITS-1:0] ver;
        logic [PAYLOAD_BITS-1:0] pay;
        logic                    mem_we;
        t_entry                  wdata;
        logic                    head_we;
        logic [HEAD_BITS-1:0]    head_new;
        logic                    used_we;
        logic [HEAD_BITS-1:0]    used_new;
    } t_exec;

endpackage

>>> src/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module ght_ram #(
    parameter int ADDR_BITS = 12,
    parameter int WIDTH     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ght_exec.sv
// ----------------------------------------------------------------------------
// ght_exec
// Modify step: decides the result and the write-back from the slot just read.
// ----------------------------------------------------------------------------
module ght_exec (
    input  ght_pkg::t_req   i_req,
    input  ght_pkg::t_entry i_rd,
    output ght_pkg::t_exec  o_res
);

    logic                             handle_ok;
    logic [ght_pkg::VERSION_BITS-1:0] bumped;

    // slot must have been appended, be live and match the version exactly
    assign handle_ok = ({1'b0, i_req.slot} < i_req.used) && i_rd.live
                       && (i_rd.version == i_req.ver);
    assign bumped    = ght_pkg::VERSION_BITS'(i_rd.version + 1'b1);

    always_comb begin
        o_res          = '0;
        o_res.status   = ght_pkg::STAT_BAD;
        o_res.slot     = i_req.slot;
        o_res.head_new = i_req.head;
        o_res.used_new = i_req.used;
        o_res.wdata    = i_rd;
        case (i_req.op)
            ght_pkg::OP_ALLOC: begin
                if (i_req.head != ght_pkg::EMPTY_MARK) begin
                    // pop the free list
                    o_res.status        = ght_pkg::STAT_OK;
                    o_res.slot          = i_req.head[ght_pkg::SLOT_BITS-1:0];
                    o_res.ver           = i_rd.version;
                    o_res.mem_we        = 1'b1;
                    o_res.wdata.live    = 1'b1;
                    o_res.wdata.payload = i_req.pay;
                    o_res.head_we       = 1'b1;
                    o_res.head_new      = i_rd.free_link;
                end else if (i_req.used != ght_pkg::EMPTY_MARK) begin
                    // append a fresh slot at version zero
                    o_res.status          = ght_pkg::STAT_OK;
                    o_res.slot            = i_req.used[ght_pkg::SLOT_BITS-1:0];
                    o_res.mem_we          = 1'b1;
                    o_res.wdata.live      = 1'b1;
                    o_res.wdata.free_link = ght_pkg::EMPTY_MARK;
                    o_res.wdata.version   = '0;
                    o_res.wdata.payload   = i_req.pay;
                    o_res.used_we         = 1'b1;
                    o_res.used_new        = ght_pkg::HEAD_BITS'(i_req.used + 1'b1);
                end else begin
                    o_res.status = ght_pkg::STAT_FULL;
                    o_res.slot   = '0;
                end
            end
            ght_pkg::OP_FREE: begin
                if (handle_ok) begin
                    o_res.status        = ght_pkg::STAT_OK;
                    o_res.ver           = bumped;
                    o_res.mem_we        = 1'b1;
                    o_res.wdata.live    = 1'b0;
                    o_res.wdata.version = bumped;
                    o_res.wdata.payload = '0;
                    // a slot at the top version retires instead of being pushed
                    if (bumped != ght_pkg::VERSION_MAX) begin
                        o_res.wdata.free_link = i_req.head;
                        o_res.head_we         = 1'b1;
                        o_res.head_new        = {1'b0, i_req.slot};
                    end
                end
            end
            ght_pkg::OP_LOOKUP: begin
                if (handle_ok) begin
                    o_res.status = ght_pkg::STAT_OK;
                    o_res.ver    = i_req.ver;
                    o_res.pay    = i_rd.payload;
                end
            end
            default: begin
                o_res.status = ght_pkg::STAT_BAD;
            end
        endcase
    end

endmodule

>>> src/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Two generational slot maps (player and general objects) kept in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction: allocate,
//   free or look up, on the table picked by i_player_table. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result per transaction,
//   in order.
//   Timing: the accept cycle issues the RAM read of the addressed slot (or of
//   the free list head on allocate); the next cycle modifies and writes the
//   slot back and loads the output register, and o_out_valid rises with that
//   load. No new transaction is taken during that modify step, because of the
//   single RAM read-modify-write per transaction.
//   A new transaction is taken while the previous result is being delivered,
//   since the output register frees up on that same edge.
//   Receiver stall: the output register holds its result; once a result waits
//   and is not taken, o_in_stall stays high.
//   Reset: both free lists empty, both tables have no slots in use, no result
//   pending. RAM contents are not cleared: only data of appended slots is used.
// ----------------------------------------------------------------------------
module generational_handle_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic        i_player_table,
    input  logic [10:0] i_slot_index,
    input  logic [23:0] i_handle_version,
    input  logic [31:0] i_payload_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [10:0] o_slot_out,
    output logic [23:0] o_version_out,
    output logic [31:0] o_payload_out
);

    // control state
    ght_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic [ght_pkg::HEAD_BITS-1:0] r_head [ght_pkg::TABLES];
    logic [ght_pkg::HEAD_BITS-1:0] r_used [ght_pkg::TABLES];

    // transaction and result registers (no reset needed)
    ght_pkg::t_req  r_req;
    ght_pkg::t_exec r_res;

    ght_pkg::t_req   n_req;
    ght_pkg::t_exec  exec_res;
    ght_pkg::t_entry rd_entry;
    logic [ght_pkg::ENTRY_BITS-1:0] rdata;

    logic                          in_accept;
    logic                          out_take;
    logic                          exec_now;
    logic [ght_pkg::SLOT_BITS-1:0] rd_slot;
    logic [ght_pkg::ADDR_BITS-1:0] raddr;
    logic [ght_pkg::ADDR_BITS-1:0] waddr;

    // ---------------------------------------------------------------- handshake
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = !((r_state == ght_pkg::ST_IDLE) && (!r_out_valid || out_take));
    assign in_accept  = i_in_valid && !o_in_stall;
    assign exec_now   = (r_state == ght_pkg::ST_EXEC);

    // ---------------------------------------------------------------- read side
    always_comb begin
        n_req      = '0;
        n_req.op   = i_opcode;
        n_req.tbl  = i_player_table;
        n_req.slot = i_slot_index;
        n_req.ver  = i_handle_version;
        n_req.pay  = i_payload_in;
        n_req.head = r_head[i_player_table];
        n_req.used = r_used[i_player_table];
    end

    // allocate reads the free list head; a bogus read on empty list is unused
    assign rd_slot = (i_opcode == ght_pkg::OP_ALLOC)
                     ? n_req.head[ght_pkg::SLOT_BITS-1:0] : i_slot_index;
    assign raddr   = {i_player_table, rd_slot};

    ght_ram #(
        .ADDR_BITS (ght_pkg::ADDR_BITS),
        .WIDTH     (ght_pkg::ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (exec_now && exec_res.mem_we),
        .i_waddr (waddr),
        .i_wdata (exec_res.wdata),
        .i_re    (in_accept),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_entry = ght_pkg::t_entry'(rdata);

    // ---------------------------------------------------------------- modify
    ght_exec u_exec (
        .i_req (r_req),
        .i_rd  (rd_entry),
        .o_res (exec_res)
    );

    assign waddr = {r_req.tbl, exec_res.slot};

    // ---------------------------------------------------------------- control
    always_comb begin
        n_state = r_state;
        case (r_state)
            ght_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = ght_pkg::ST_EXEC;
                end
            end
            ght_pkg::ST_EXEC: begin
                n_state = ght_pkg::ST_IDLE;
            end
            default: begin
                n_state = ght_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (exec_now) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ght_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            for (int t = 0; t < ght_pkg::TABLES; t++) begin
                r_head[t] <= ght_pkg::EMPTY_MARK;
                r_used[t] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (exec_now && exec_res.head_we) begin
                r_head[r_req.tbl] <= exec_res.head_new;
            end
            if (exec_now && exec_res.used_we) begin
                r_used[r_req.tbl] <= exec_res.used_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= n_req;
        end
        if (exec_now) begin
            r_res <= exec_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_res.status;
    assign o_slot_out    = r_res.slot;
    assign o_version_out = r_res.ver;
    assign o_payload_out = r_res.pay;

`ifndef SYNTHESIS
    // every accepted transaction has its result up once its execute state is done
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> ##1 o_out_valid)
        else $error("no result after accepted transaction");

    // no transaction is taken while one is executing
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_now |-> o_in_stall)
        else $error("transaction accepted during execute");

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used[0] <= ght_pkg::EMPTY_MARK) && (r_used[1] <= ght_pkg::EMPTY_MARK))
        else $error("slots in use beyond table size");

    // free list head is empty or names an appended slot
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_head[0] == ght_pkg::EMPTY_MARK) || (r_head[0] < r_used[0]))
        && ((r_head[1] == ght_pkg::EMPTY_MARK) || (r_head[1] < r_used[1])))
        else $error("free list head outside appended slots");
`endif

endmodule
